[src/sfce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_pkg: shared types and constants of the SPI NOR command engine
// Transfer structs, item kinds, opcodes and error codes.
// ----------------------------------------------------------------------------
package sfce_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_WAKE    = 3'd1;
    localparam logic [2:0] KIND_ERASE   = 3'd2;
    localparam logic [2:0] KIND_PROGRAM = 3'd3;
    localparam logic [2:0] KIND_READ    = 3'd4;
    localparam logic [2:0] KIND_LOAD    = 3'd5;

    localparam logic [7:0] OP_WREN   = 8'h06;
    localparam logic [7:0] OP_ERASE  = 8'h20;
    localparam logic [7:0] OP_PROG   = 8'h02;
    localparam logic [7:0] OP_READ   = 8'h03;
    localparam logic [7:0] OP_STATUS = 8'h05;
    localparam logic [7:0] OP_WAKE   = 8'hAB;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MISALIGN  = 2'd1;
    localparam logic [1:0] ERR_BUSY      = 2'd2;

    typedef enum logic [1:0] {
        CMD_WAKE    = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_PROGRAM = 2'd2,
        CMD_READ    = 2'd3
    } cmd_sel_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [7:0]  data_byte;
        logic        miso;
    } cmd_item_t;

    typedef struct packed {
        logic        sck;
        logic        mosi;
        logic        cs_n;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  error_code;
    } rsp_item_t;

    typedef struct packed {
        logic        tick;
        logic        cmd;
        logic        load;
        cmd_sel_t    cmd_sel;
        logic        misaligned;
        logic [23:0] address;
        logic [7:0]  data_byte;
        logic        miso;
    } work_item_t;

endpackage

[src/sfce_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read returns old contents.
// ----------------------------------------------------------------------------
module sfce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/sfce_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_front: input queue and item classification
// Decodes the kind, checks alignment and buffers two items for the back end.
// ----------------------------------------------------------------------------
module sfce_front #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sfce_pkg::cmd_item_t cmd_data,
    output logic                item_valid,
    output sfce_pkg::work_item_t item,
    input  logic                item_pop
);
    import sfce_pkg::*;

    work_item_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    work_item_t cls;
    logic       push;

    always_comb
    begin
        cls            = '0;
        cls.address    = cmd_data.address;
        cls.data_byte  = cmd_data.data_byte;
        cls.miso       = cmd_data.miso;
        cls.tick       = (cmd_data.kind == KIND_TICK);
        cls.load       = (cmd_data.kind == KIND_LOAD);
        cls.cmd        = 1'b1;
        cls.cmd_sel    = CMD_WAKE;
        unique case (cmd_data.kind)
            KIND_WAKE:    cls.cmd_sel = CMD_WAKE;
            KIND_ERASE:   cls.cmd_sel = CMD_ERASE;
            KIND_PROGRAM: cls.cmd_sel = CMD_PROGRAM;
            KIND_READ:    cls.cmd_sel = CMD_READ;
            default:      cls.cmd     = 1'b0;
        endcase
        cls.misaligned =
            ((cmd_data.kind == KIND_ERASE) &&
             ((cmd_data.address % SECTOR_BYTES) != 0)) ||
            ((cmd_data.kind == KIND_PROGRAM) &&
             ((cmd_data.address % PAGE_BYTES) != 0));
    end

    assign cmd_stall  = (count_reg == 2'd2);
    assign push       = cmd_valid && !cmd_stall;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ item_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

[src/sfce_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfce_back: SPI frame sequencer and output register
// Runs one item per cycle while rsp_stall allows and registers its result.
// ----------------------------------------------------------------------------
module sfce_back #(
    parameter int PAGE_BYTES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          wake_delay_ticks,
    input  logic [7:0]           cs_gap_ticks,
    input  logic                 item_valid,
    input  sfce_pkg::work_item_t item,
    output logic                 item_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output sfce_pkg::rsp_item_t  rsp_data
);
    import sfce_pkg::*;

    localparam int PIDX_W    = $clog2(PAGE_BYTES);
    localparam int BC_W      = $clog2(PAGE_BYTES + ADDR_BYTES + 2);
    localparam int AB_W      = $clog2(ADDR_BYTES + 1);
    localparam logic [BC_W-1:0] LEN_ONE  = BC_W'(1);
    localparam logic [BC_W-1:0] LEN_POLL = BC_W'(2);
    localparam logic [BC_W-1:0] LEN_ER   = BC_W'(1 + ADDR_BYTES);
    localparam logic [BC_W-1:0] LEN_PAGE = BC_W'(1 + ADDR_BYTES + PAGE_BYTES);
    localparam logic [BC_W-1:0] BC_ABYTES = BC_W'(ADDR_BYTES);

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_WAKE_TX   = 12'b0000_0000_0010,
        PH_WAKE_WAIT = 12'b0000_0000_0100,
        PH_ER_WREN   = 12'b0000_0000_1000,
        PH_ER_GAP    = 12'b0000_0001_0000,
        PH_ER_CMD    = 12'b0000_0010_0000,
        PH_PG_WREN   = 12'b0000_0100_0000,
        PH_PG_GAP    = 12'b0000_1000_0000,
        PH_PG_CMD    = 12'b0001_0000_0000,
        PH_RD_CMD    = 12'b0010_0000_0000,
        PH_POLL_GAP  = 12'b0100_0000_0000,
        PH_POLL_TX   = 12'b1000_0000_0000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0]      bit_count_reg, bit_count_next;
    logic            half_bit_reg, half_bit_next;
    logic [7:0]      shift_out_reg, shift_out_next;
    logic [7:0]      shift_in_reg, shift_in_next;
    logic [BC_W-1:0] byte_count_reg, byte_count_next;
    logic [23:0]     target_reg, target_next;
    logic [15:0]     delay_reg, delay_next;
    logic            byp_hit_reg, byp_hit_next;
    logic [7:0]      byp_data_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_data_reg;
    rsp_item_t       res;

    logic [PIDX_W-1:0] buf_raddr;
    logic [7:0]        buf_rdata;
    logic [7:0]        buf_byte;
    logic              buf_we;

    logic            done, rvalid, fr_now, fr_next;
    logic [1:0]      err;
    logic [7:0]      rbyte;
    logic [BC_W-1:0] bc_inc, flen;
    logic [7:0]      next_byte, addr_byte;
    logic [7:0]      gap_reload;
    logic [AB_W-1:0] addr_sel;
    logic [31:0]     target_ext;

    function automatic logic in_frame(phase_t ph);
        return (ph == PH_WAKE_TX) || (ph == PH_ER_WREN) || (ph == PH_ER_CMD) ||
               (ph == PH_PG_WREN) || (ph == PH_PG_CMD) || (ph == PH_RD_CMD) ||
               (ph == PH_POLL_TX);
    endfunction

    function automatic logic [7:0] first_byte(phase_t ph);
        logic [7:0] b;
        b = FILL_BYTE;
        unique case (ph)
            PH_WAKE_TX:             b = OP_WAKE;
            PH_ER_WREN, PH_PG_WREN: b = OP_WREN;
            PH_ER_CMD:              b = OP_ERASE;
            PH_PG_CMD:              b = OP_PROG;
            PH_RD_CMD:              b = OP_READ;
            PH_POLL_TX:             b = OP_STATUS;
            default:                b = FILL_BYTE;
        endcase
        return b;
    endfunction

    sfce_ram #(
        .WIDTH(8),
        .DEPTH(PAGE_BYTES)
    ) u_page_buf (
        .clk  (clk),
        .we   (buf_we),
        .waddr(item.address[PIDX_W-1:0]),
        .wdata(item.data_byte),
        .raddr(buf_raddr),
        .rdata(buf_rdata)
    );

    assign item_pop = item_valid && !(rsp_valid_reg && rsp_stall);
    assign buf_we   = item_pop && item.load;
    // prefetch the buffer entry the next byte boundary will need
    assign buf_raddr = PIDX_W'(byte_count_reg - BC_ABYTES);
    assign buf_byte  = byp_hit_reg ? byp_data_reg : buf_rdata;
    assign byp_hit_next = buf_we && (item.address[PIDX_W-1:0] == buf_raddr);

    assign target_ext = {8'h00, target_reg};
    assign bc_inc     = byte_count_reg + LEN_ONE;
    assign addr_sel   = AB_W'(ADDR_BYTES) - AB_W'(bc_inc);
    assign addr_byte  = target_ext[{addr_sel, 3'b000} +: 8];
    assign gap_reload = (cs_gap_ticks == 8'd0) ? 8'd0 : cs_gap_ticks - 8'd1;
    assign fr_now     = in_frame(phase_reg);

    always_comb
    begin
        flen = LEN_ONE;
        unique case (phase_reg)
            PH_ER_CMD:            flen = LEN_ER;
            PH_PG_CMD, PH_RD_CMD: flen = LEN_PAGE;
            PH_POLL_TX:           flen = LEN_POLL;
            default:              flen = LEN_ONE;
        endcase

        if ((phase_reg == PH_ER_CMD) || (phase_reg == PH_PG_CMD) ||
            (phase_reg == PH_RD_CMD))
        begin
            if (bc_inc <= BC_ABYTES)
            begin
                next_byte = addr_byte;
            end
            else if (phase_reg == PH_PG_CMD)
            begin
                next_byte = buf_byte;
            end
            else
            begin
                next_byte = FILL_BYTE;
            end
        end
        else
        begin
            next_byte = FILL_BYTE;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        half_bit_next   = half_bit_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        byte_count_next = byte_count_reg;
        target_next     = target_reg;
        delay_next      = delay_reg;
        done            = 1'b0;
        rvalid          = 1'b0;
        rbyte           = 8'd0;
        err             = ERR_NONE;

        if (item.tick)
        begin
            if (fr_now)
            begin
                if (!half_bit_reg)
                begin
                    half_bit_next = 1'b1;
                    shift_in_next = {shift_in_reg[6:0], item.miso};
                end
                else
                begin
                    half_bit_next  = 1'b0;
                    shift_out_next = {shift_out_reg[6:0], 1'b0};
                    bit_count_next = bit_count_reg + 3'd1;
                    if (bit_count_reg == 3'd7)
                    begin
                        if ((phase_reg == PH_RD_CMD) && (byte_count_reg > BC_ABYTES))
                        begin
                            rvalid = 1'b1;
                            rbyte  = shift_in_reg;
                        end
                        byte_count_next = bc_inc;
                        if (bc_inc < flen)
                        begin
                            shift_out_next = next_byte;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_WAKE_TX:
                                begin
                                    if (wake_delay_ticks == 16'd0)
                                    begin
                                        phase_next = PH_IDLE;
                                        done       = 1'b1;
                                    end
                                    else
                                    begin
                                        delay_next = wake_delay_ticks;
                                        phase_next = PH_WAKE_WAIT;
                                    end
                                end
                                PH_ER_WREN:
                                begin
                                    phase_next = PH_ER_GAP;
                                    delay_next = {8'd0, gap_reload};
                                end
                                PH_PG_WREN:
                                begin
                                    phase_next = PH_PG_GAP;
                                    delay_next = {8'd0, gap_reload};
                                end
                                PH_ER_CMD, PH_PG_CMD:
                                begin
                                    phase_next = PH_POLL_GAP;
                                    delay_next = {8'd0, gap_reload};
                                end
                                PH_POLL_TX:
                                begin
                                    // keep polling while the flash reports busy
                                    if (shift_in_reg[0])
                                    begin
                                        phase_next = PH_POLL_GAP;
                                        delay_next = {8'd0, gap_reload};
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                        done       = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAKE_WAIT:
                    begin
                        delay_next = delay_reg - 16'd1;
                        if (delay_reg == 16'd1)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    PH_ER_GAP, PH_PG_GAP, PH_POLL_GAP:
                    begin
                        if (delay_reg == 16'd0)
                        begin
                            priority case (phase_reg)
                                PH_ER_GAP: phase_next = PH_ER_CMD;
                                PH_PG_GAP: phase_next = PH_PG_CMD;
                                default:   phase_next = PH_POLL_TX;
                            endcase
                            byte_count_next = '0;
                            bit_count_next  = 3'd0;
                            half_bit_next   = 1'b0;
                            shift_in_next   = 8'd0;
                            shift_out_next  = first_byte(phase_next);
                        end
                        else
                        begin
                            delay_next = delay_reg - 16'd1;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
        else if (item.cmd)
        begin
            if (phase_reg != PH_IDLE)
            begin
                err = ERR_BUSY;
            end
            else if (item.misaligned)
            begin
                err  = ERR_MISALIGN;
                done = 1'b1;
            end
            else
            begin
                target_next = item.address;
                unique case (item.cmd_sel)
                    CMD_WAKE:    phase_next = PH_WAKE_TX;
                    CMD_ERASE:   phase_next = PH_ER_WREN;
                    CMD_PROGRAM: phase_next = PH_PG_WREN;
                    CMD_READ:    phase_next = PH_RD_CMD;
                    default:     phase_next = PH_IDLE;
                endcase
                byte_count_next = '0;
                bit_count_next  = 3'd0;
                half_bit_next   = 1'b0;
                shift_in_next   = 8'd0;
                shift_out_next  = first_byte(phase_next);
            end
        end

        fr_next        = in_frame(phase_next);
        res.sck        = fr_next && half_bit_next;
        res.mosi       = fr_next && shift_out_next[7];
        res.cs_n       = !fr_next;
        res.read_valid = rvalid;
        res.read_byte  = rbyte;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.error_code = err;
    end

    always_comb
    begin
        if (item_pop)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk)
    begin
        byp_data_reg <= item.data_byte;
        if (item_pop)
        begin
            rsp_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 3'd0;
            half_bit_reg   <= 1'b0;
            shift_out_reg  <= 8'd0;
            shift_in_reg   <= 8'd0;
            byte_count_reg <= '0;
            target_reg     <= 24'd0;
            delay_reg      <= 16'd0;
            byp_hit_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            byp_hit_reg   <= byp_hit_next;
            rsp_valid_reg <= rsp_valid_next;
            if (item_pop)
            begin
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                half_bit_reg   <= half_bit_next;
                shift_out_reg  <= shift_out_next;
                shift_in_reg   <= shift_in_next;
                byte_count_reg <= byte_count_next;
                target_reg     <= target_next;
                delay_reg      <= delay_next;
            end
        end
    end
endmodule

[src/spi_nor_flash_command_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_nor_flash_command_engine: SPI mode 0 NOR flash command engine
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------
//   cmd      | in        | cmd_valid/cmd_stall | sfce_pkg::cmd_item_t
//   rsp      | out       | rsp_valid/rsp_stall | sfce_pkg::rsp_item_t
//   apb      | in        | psel/penable/pready | wake delay, cs gap
//
// One item per clock cycle sustained while rsp_stall is low. Each item passes
// a queue slot, then the sequencer and the output register holding its result.
// The two-entry input queue takes items while a result waits on rsp_stall.
// Reset leaves the engine idle with registers at their defaults.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_engine #(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  sfce_pkg::cmd_item_t cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sfce_pkg::rsp_item_t rsp_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import sfce_pkg::*;

    localparam logic REG_WAKE = 1'b0;
    localparam logic REG_GAP  = 1'b1;

    logic [15:0] wake_delay_reg, wake_delay_next;
    logic [7:0]  cs_gap_reg, cs_gap_next;
    logic        cfg_wr;
    logic        item_valid, item_pop;
    work_item_t  item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        wake_delay_next = wake_delay_reg;
        cs_gap_next     = cs_gap_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WAKE: wake_delay_next = pwdata[15:0];
                REG_GAP:  cs_gap_next     = pwdata[7:0];
                default:  wake_delay_next = wake_delay_reg;
            endcase
        end
        prdata = (paddr[2] == REG_GAP) ? {24'd0, cs_gap_reg} : {16'd0, wake_delay_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_delay_reg <= 16'd1000;
            cs_gap_reg     <= 8'd1;
        end
        else
        begin
            wake_delay_reg <= wake_delay_next;
            cs_gap_reg     <= cs_gap_next;
        end
    end

    sfce_front #(
        .PAGE_BYTES  (PAGE_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .item_valid(item_valid),
        .item      (item),
        .item_pop  (item_pop)
    );

    sfce_back #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .wake_delay_ticks(wake_delay_reg),
        .cs_gap_ticks    (cs_gap_reg),
        .item_valid      (item_valid),
        .item            (item),
        .item_pop        (item_pop),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_data        (rsp_data)
    );

    a_sck_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.sck |-> !rsp_data.cs_n)
        else $error("sck high outside a frame");

    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.error_code == ERR_BUSY) |-> !rsp_data.done_res)
        else $error("rejected command reported done");

    a_read_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.read_valid |-> rsp_data.busy_res || rsp_data.done_res)
        else $error("read byte outside a command");

    a_rsp_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> rsp_valid)
        else $error("result lost after queue pop");
endmodule

[test/spi_nor_flash_command_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_nor_flash_command_engine_tb: self-checking bench of the SPI NOR engine
// A table of directed commands, some followed by ticks until the engine goes
// idle, then random command streams, each command followed by such ticks.
// An in-bench model predicts each result the table does not set. Commands idle
// and results stall at random; the register port is written between phases.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_engine_tb;
    import sfce_pkg::*;

    localparam int PAGE_LEN   = 256;
    localparam int SECTOR_LEN = 4096;
    localparam int WATCHDOG   = 4000;
    localparam int DRAIN_WAIT = 4;
    localparam logic [2:0] REG_WAKE_DELAY = 3'd0;
    localparam logic [2:0] REG_CS_GAP     = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE_TX, PH_WAKE_WAIT, PH_ER_WREN, PH_ER_GAP, PH_ER_CMD,
        PH_PG_WREN, PH_PG_GAP, PH_PG_CMD, PH_RD_CMD, PH_POLL_GAP, PH_POLL_TX
    } engine_phase_t;

    typedef struct {
        cmd_item_t item;
        bit        typed;
        rsp_item_t want;
        bit        run_out;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_item_t   cmd_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // engine model state
    engine_phase_t ph;
    logic [2:0]    bit_cnt;
    logic          half;
    logic [7:0]    sh_out, sh_in;
    int            byte_cnt;
    logic [23:0]   tgt_addr;
    logic [15:0]   delay_cnt;
    logic [7:0]    page_mem [PAGE_LEN];
    logic [15:0]   cfg_wake;
    logic [7:0]    cfg_gap;

    rsp_item_t     expected_rsp [$];
    int            errors = 0;
    int            tx_idle = 0;
    int            rx_idle = 0;
    bit            hold_request = 1'b0;
    int            quiet_cycles = 0;

    spi_nor_flash_command_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    function automatic bit in_frame();
        return ph inside {PH_WAKE_TX, PH_ER_WREN, PH_ER_CMD, PH_PG_WREN, PH_PG_CMD,
                          PH_RD_CMD, PH_POLL_TX};
    endfunction

    function automatic int frame_len();
        case (ph)
            PH_ER_CMD: return 1 + ADDR_BYTES;
            PH_PG_CMD, PH_RD_CMD: return 1 + ADDR_BYTES + PAGE_LEN;
            PH_POLL_TX: return 2;
            default: return 1;
        endcase
    endfunction

    function automatic logic [7:0] frame_byte(int idx);
        int j;
        if (idx == 0) begin
            case (ph)
                PH_WAKE_TX: return OP_WAKE;
                PH_ER_WREN, PH_PG_WREN: return OP_WREN;
                PH_ER_CMD: return OP_ERASE;
                PH_PG_CMD: return OP_PROG;
                PH_RD_CMD: return OP_READ;
                PH_POLL_TX: return OP_STATUS;
                default: return FILL_BYTE;
            endcase
        end
        if (!(ph inside {PH_ER_CMD, PH_PG_CMD, PH_RD_CMD}))
            return FILL_BYTE;
        if (idx <= ADDR_BYTES)
            return 8'(tgt_addr >> (8 * (ADDR_BYTES - idx)));
        j = idx - 1 - ADDR_BYTES;
        if (ph == PH_PG_CMD && j < PAGE_LEN)
            return page_mem[j];
        return FILL_BYTE;
    endfunction

    function automatic void start_frame(engine_phase_t next);
        ph = next;
        byte_cnt = 0;
        bit_cnt = '0;
        half = 1'b0;
        sh_in = '0;
        sh_out = frame_byte(0);
    endfunction

    function automatic logic [15:0] gap_reload();
        return (cfg_gap == 0) ? 16'd0 : 16'(cfg_gap - 1);
    endfunction

    function automatic void end_frame(output logic done);
        done = 1'b0;
        case (ph)
            PH_WAKE_TX: begin
                if (cfg_wake == 0) begin
                    ph = PH_IDLE;
                    done = 1'b1;
                end else begin
                    delay_cnt = cfg_wake;
                    ph = PH_WAKE_WAIT;
                end
            end
            PH_ER_WREN: begin ph = PH_ER_GAP; delay_cnt = gap_reload(); end
            PH_PG_WREN: begin ph = PH_PG_GAP; delay_cnt = gap_reload(); end
            PH_ER_CMD, PH_PG_CMD: begin ph = PH_POLL_GAP; delay_cnt = gap_reload(); end
            PH_POLL_TX: begin
                // keep polling while the flash reports write in progress
                if (sh_in[0]) begin
                    ph = PH_POLL_GAP;
                    delay_cnt = gap_reload();
                end else begin
                    ph = PH_IDLE;
                    done = 1'b1;
                end
            end
            default: begin ph = PH_IDLE; done = 1'b1; end
        endcase
    endfunction

    function automatic void serial_tick(input logic miso, output logic done,
                                        output logic rv, output logic [7:0] rb);
        done = 1'b0;
        rv = 1'b0;
        rb = '0;
        if (in_frame()) begin
            if (!half) begin
                half = 1'b1;
                sh_in = {sh_in[6:0], miso};
                return;
            end
            half = 1'b0;
            sh_out = {sh_out[6:0], 1'b0};
            bit_cnt = bit_cnt + 3'd1;
            if (bit_cnt != 0)
                return;
            if (ph == PH_RD_CMD && byte_cnt >= 1 + ADDR_BYTES) begin
                rv = 1'b1;
                rb = sh_in;
            end
            byte_cnt++;
            if (byte_cnt < frame_len()) begin
                sh_out = frame_byte(byte_cnt);
                return;
            end
            end_frame(done);
            return;
        end
        case (ph)
            PH_WAKE_WAIT: begin
                delay_cnt = delay_cnt - 16'd1;
                if (delay_cnt == 0) begin
                    ph = PH_IDLE;
                    done = 1'b1;
                end
            end
            PH_ER_GAP, PH_PG_GAP, PH_POLL_GAP: begin
                if (delay_cnt == 0)
                    start_frame(ph == PH_ER_GAP ? PH_ER_CMD :
                                ph == PH_PG_GAP ? PH_PG_CMD : PH_POLL_TX);
                else
                    delay_cnt = delay_cnt - 16'd1;
            end
            default: ph = PH_IDLE;
        endcase
    endfunction

    function automatic rsp_item_t engine_step(cmd_item_t it);
        rsp_item_t r;
        logic done, rv, fr;
        logic [7:0] rb;
        logic [1:0] err;
        done = 1'b0;
        rv = 1'b0;
        rb = '0;
        err = ERR_NONE;
        case (it.kind)
            KIND_TICK: serial_tick(it.miso, done, rv, rb);
            KIND_WAKE, KIND_ERASE, KIND_PROGRAM, KIND_READ: begin
                if (ph != PH_IDLE) begin
                    err = ERR_BUSY;
                end else if ((it.kind == KIND_ERASE && it.address % SECTOR_LEN != 0) ||
                             (it.kind == KIND_PROGRAM && it.address % PAGE_LEN != 0)) begin
                    err = ERR_MISALIGN;
                    done = 1'b1;
                end else begin
                    tgt_addr = it.address;
                    start_frame(it.kind == KIND_WAKE ? PH_WAKE_TX :
                                it.kind == KIND_ERASE ? PH_ER_WREN :
                                it.kind == KIND_PROGRAM ? PH_PG_WREN : PH_RD_CMD);
                end
            end
            KIND_LOAD: page_mem[it.address % PAGE_LEN] = it.data_byte;
            default: ;
        endcase
        fr = in_frame();
        r.sck = fr && half;
        r.mosi = fr && sh_out[7];
        r.cs_n = !fr;
        r.read_valid = rv;
        r.read_byte = rb;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = done;
        r.error_code = err;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // offer one transfer; typed expectation overrides the prediction
    task automatic send_item(cmd_item_t it, bit typed = 1'b0, rsp_item_t want = '0);
        rsp_item_t predicted;
        while ($urandom_range(99) < tx_idle) begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_data <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = engine_step(it);
        expected_rsp.push_back(typed ? want : predicted);
    endtask

    function automatic cmd_item_t make_item(logic [2:0] kind, logic [23:0] address,
                                            logic [7:0] data_byte, logic miso);
        cmd_item_t it;
        it.kind = kind;
        it.address = address;
        it.data_byte = data_byte;
        it.miso = miso;
        return it;
    endfunction

    // tick until the engine is idle, with stray transfers mixed in
    task automatic run_out(int noise_pct);
        while (ph != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct)
                send_item(make_item(3'($urandom_range(1, 7)), 24'($urandom),
                                    8'($urandom), 1'($urandom)));
            else
                send_item(make_item(KIND_TICK, 24'($urandom), 8'($urandom),
                                    1'($urandom)));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_WAKE_DELAY)
            cfg_wake = value[15:0];
        else
            cfg_gap = value[7:0];
    endtask

    task automatic random_commands(int count, int wake_pct);
        int r;
        logic [23:0] a;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            a = 24'($urandom);
            if (r < wake_pct)
                send_item(make_item(KIND_WAKE, a, 8'($urandom), 1'($urandom)));
            else if (r < 45)
                send_item(make_item(KIND_ERASE, {a[23:12], 12'h000}, 8'($urandom),
                                    1'($urandom)));
            else if (r < 55)
                send_item(make_item(KIND_PROGRAM, {a[23:8], 8'h00}, 8'($urandom),
                                    1'($urandom)));
            else if (r < 65)
                send_item(make_item(KIND_READ, a, 8'($urandom), 1'($urandom)));
            else if (r < 75)
                send_item(make_item(3'($urandom_range(KIND_ERASE, KIND_PROGRAM)),
                                    a | 24'h1, 8'($urandom), 1'($urandom)));
            else
                repeat ($urandom_range(1, 8))
                    send_item(make_item(3'($urandom_range(0, 7)) == KIND_TICK ?
                                        KIND_TICK : 3'($urandom_range(5, 7)),
                                        24'($urandom), 8'($urandom), 1'($urandom)));
            run_out(2);
        end
    endtask

    // receiver side: random stall, plus one long hold on request
    always @(negedge clk) begin
        static int hold_left = 0;
        if (hold_request && hold_left == 0)
            hold_left = 400;
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
            if (hold_left == 0)
                hold_request = 1'b0;
        end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    always @(posedge clk) begin
        rsp_item_t want;
        if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("unexpected transfer", rsp_data, 0);
            end else begin
                want = expected_rsp.pop_front();
                if (rsp_data.sck !== want.sck)
                    report_mismatch("sck", rsp_data.sck, want.sck);
                if (rsp_data.mosi !== want.mosi)
                    report_mismatch("mosi", rsp_data.mosi, want.mosi);
                if (rsp_data.cs_n !== want.cs_n)
                    report_mismatch("cs_n", rsp_data.cs_n, want.cs_n);
                if (rsp_data.read_valid !== want.read_valid)
                    report_mismatch("read_valid", rsp_data.read_valid, want.read_valid);
                if (rsp_data.read_byte !== want.read_byte)
                    report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
                if (rsp_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", rsp_data.busy_res, want.busy_res);
                if (rsp_data.done_res !== want.done_res)
                    report_mismatch("done_res", rsp_data.done_res, want.done_res);
                if (rsp_data.error_code !== want.error_code)
                    report_mismatch("error_code", rsp_data.error_code, want.error_code);
            end
        end
    end

    always @(posedge clk) begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        directed_row_t rows [$];
        directed_row_t row;
        rsp_item_t idle_rsp, busy_rsp;

        idle_rsp = '0;
        idle_rsp.cs_n = 1'b1;
        busy_rsp = '0;
        busy_rsp.busy_res = 1'b1;

        ph = PH_IDLE;
        bit_cnt = '0;
        half = 1'b0;
        sh_out = '0;
        sh_in = '0;
        byte_cnt = 0;
        tgt_addr = '0;
        delay_cnt = '0;
        cfg_wake = 16'd1000;
        cfg_gap = 8'd1;

        row = '{make_item(KIND_TICK, 24'h0, 8'h0, 1'b1), 1'b1, idle_rsp, 1'b0};
        rows.push_back(row);
        row.item = make_item(KIND_ERASE, 24'h000001, 8'h0, 1'b0);
        row.want = idle_rsp;
        row.want.done_res = 1'b1;
        row.want.error_code = ERR_MISALIGN;
        rows.push_back(row);
        row.item = make_item(KIND_PROGRAM, 24'hFFFF80, 8'h0, 1'b0);
        rows.push_back(row);
        row.item = make_item(3'd6, 24'hFFFFFF, 8'hFF, 1'b1);
        row.want = idle_rsp;
        rows.push_back(row);
        row.item = make_item(3'd7, 24'h000000, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_LOAD, 24'hFFFFFF, 8'hFF, 1'b1);
        rows.push_back(row);
        // read opcode starts with a zero bit on the line
        row.item = make_item(KIND_READ, 24'hFFFFFF, 8'h00, 1'b0);
        row.want = busy_rsp;
        rows.push_back(row);
        row.item = make_item(KIND_WAKE, 24'h000000, 8'h00, 1'b0);
        row.want.error_code = ERR_BUSY;
        row.run_out = 1'b1;
        rows.push_back(row);
        row.item = make_item(KIND_ERASE, 24'h000000, 8'h00, 1'b0);
        row.want = busy_rsp;
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = make_item(KIND_ERASE, 24'hFFF000, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_PROGRAM, 24'hFFFF00, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_PROGRAM, 24'h000000, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_WAKE, 24'h123456, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_READ, 24'h000000, 8'h00, 1'b0);
        rows.push_back(row);
        row.item = make_item(KIND_LOAD, 24'h000000, 8'h00, 1'b0);
        row.run_out = 1'b0;
        rows.push_back(row);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle = 10;
        rx_idle = 58;
        // every buffer entry gets written before any program
        for (int i = 0; i < PAGE_LEN; i++)
            send_item(make_item(KIND_LOAD, 24'(i), 8'($urandom), 1'b0));
        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].typed, rows[i].want);
            if (rows[i].run_out)
                run_out(0);
        end
        wait_drained();

        write_reg(REG_WAKE_DELAY, 32'd0);
        write_reg(REG_CS_GAP, 32'd0);
        random_commands(14, 15);
        wait_drained();

        write_reg(REG_WAKE_DELAY, 32'd65535);
        write_reg(REG_CS_GAP, 32'd255);
        tx_idle = 58;
        rx_idle = 10;
        hold_request = 1'b1;
        random_commands(10, 5);
        wait_drained();

        write_reg(REG_WAKE_DELAY, 32'($urandom_range(1, 3000)));
        write_reg(REG_CS_GAP, 32'($urandom_range(1, 255)));
        tx_idle = 0;
        rx_idle = 0;
        random_commands(14, 15);
        wait_drained();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
